>>> src/dts_pkg.sv
// Shared types, codes and constants for the DFS topological sort core.
`timescale 1ns / 1ps

package dts_pkg;

	// Default sizes of the graph stores
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;

	// Fixed port widths
	localparam int VERTEX_W = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	// Reply status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Request codes
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_SORT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LINK,
		S_REPLY,
		S_CLR,
		S_ROOT,
		S_ROOTH,
		S_VISIT,
		S_EDGE,
		S_HEAD,
		S_POP,
		S_ERD,
		S_EOUT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic edge_accept;
		logic edge_link;
		logic reply_load;
		logic clr;
		logic root_next;
		logic root_start;
		logic load_head;
		logic edge_read;
		logic edge_take;
		logic pop;
		logic pop_load;
		logic emit_init;
		logic emit_read;
		logic emit_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_sort;
		logic edge_ok;
		logic root_done;
		logic root_seen;
		logic top_nil;
		logic descend;
		logic sp_one;
		logic idx_zero;
		logic out_free;
	} stat_t;

endpackage

>>> src/dts_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/dts_datapath.sv
// Datapath: edge store, adjacency lists, search and finish stacks, output register.
`timescale 1ns / 1ps

module dts_datapath #(
	parameter int MAX_VERTICES = dts_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = dts_pkg::MAX_EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dts_pkg::cmd_t                 cmd,
	output dts_pkg::stat_t                stat,
	input  logic                          cfg_we,
	input  logic [dts_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          req_type,
	input  logic [dts_pkg::VERTEX_W-1:0]  edge_from,
	input  logic [dts_pkg::VERTEX_W-1:0]  edge_to,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dts_pkg::VERTEX_W-1:0]  vertex,
	output logic                          last,
	output logic [dts_pkg::STATUS_W-1:0]  status
);

	localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam logic [CW-1:0] NIL  = CW'(MAX_EDGES);
	localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);

	logic [dts_pkg::COUNT_W-1:0]  count_q;
	logic [NW-1:0]                n;
	logic [VW-1:0]                from_q;
	logic [CW-1:0]                used_q;
	logic [dts_pkg::STATUS_W-1:0] status_q;
	logic [MAX_VERTICES-1:0]      visited_q;
	logic [MAX_VERTICES-1:0]      has_list_q;
	logic [NW-1:0]                root_q;
	logic [VW-1:0]                top_v_q;
	logic [CW-1:0]                top_cur_q;
	logic [NW-1:0]                sp_q;
	logic [NW-1:0]                fin_q;
	logic [VW-1:0]                idx_q;
	logic                         out_valid_q;
	logic [VW-1:0]                out_vertex_q;
	logic                         out_last_q;
	logic [dts_pkg::STATUS_W-1:0] out_status_q;

	logic [dts_pkg::STATUS_W-1:0] acc_status;
	logic                         descend;

	// RAM ports
	logic           dest_we, next_we, head_we, tail_we, head_re;
	logic [EAW-1:0] next_waddr;
	logic [CW-1:0]  next_wdata;
	logic [VW-1:0]  dest_rd, finish_rd, head_raddr;
	logic [CW-1:0]  next_rd;
	logic [EAW-1:0] head_rd, tail_rd;
	logic [VW+CW-1:0] stack_rd;

	// Clamp the vertex count to 1..MAX_VERTICES
	always_comb begin
		if (count_q == '0) begin
			n = NW'(1);
		end else if (int'(count_q) > MAX_VERTICES) begin
			n = NMAX;
		end else begin
			n = NW'(count_q);
		end
	end

	// Check an incoming edge
	always_comb begin
		if (int'(edge_from) >= int'(n) || int'(edge_to) >= int'(n)) begin
			acc_status = dts_pkg::ST_RANGE;
		end else if (used_q == NIL) begin
			acc_status = dts_pkg::ST_FULL;
		end else begin
			acc_status = dts_pkg::ST_OK;
		end
	end

	// Descend into an in-range, unseen successor while the search stack has room
	assign descend = (int'(dest_rd) < int'(n)) && !visited_q[dest_rd] && (sp_q < NMAX);

	assign stat.is_sort   = (req_type == dts_pkg::REQ_SORT);
	assign stat.edge_ok   = (acc_status == dts_pkg::ST_OK);
	assign stat.root_done = (root_q >= n);
	assign stat.root_seen = visited_q[root_q[VW-1:0]];
	assign stat.top_nil   = (top_cur_q == NIL);
	assign stat.descend   = descend;
	assign stat.sp_one    = (sp_q == NW'(1));
	assign stat.idx_zero  = (idx_q == '0);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Edge store writes and list linking
	assign dest_we    = cmd.edge_accept && stat.edge_ok;
	assign next_we    = dest_we || (cmd.edge_link && has_list_q[from_q]);
	assign next_waddr = cmd.edge_link ? tail_rd : used_q[EAW-1:0];
	assign next_wdata = cmd.edge_link ? used_q : NIL;
	assign head_we    = cmd.edge_link && !has_list_q[from_q];
	assign tail_we    = cmd.edge_link;
	assign head_re    = cmd.root_start || (cmd.edge_take && descend);
	assign head_raddr = cmd.root_start ? root_q[VW-1:0] : dest_rd;

	dts_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_dest (
		.clk(clk), .we(dest_we), .waddr(used_q[EAW-1:0]), .wdata(edge_to[VW-1:0]),
		.re(cmd.edge_read), .raddr(top_cur_q[EAW-1:0]), .rdata(dest_rd)
	);

	dts_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.re(cmd.edge_read), .raddr(top_cur_q[EAW-1:0]), .rdata(next_rd)
	);

	dts_ram #(.WIDTH(EAW), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(head_we), .waddr(from_q), .wdata(used_q[EAW-1:0]),
		.re(head_re), .raddr(head_raddr), .rdata(head_rd)
	);

	dts_ram #(.WIDTH(EAW), .DEPTH(MAX_VERTICES)) u_tail (
		.clk(clk), .we(tail_we), .waddr(from_q), .wdata(used_q[EAW-1:0]),
		.re(cmd.edge_accept), .raddr(edge_from[VW-1:0]), .rdata(tail_rd)
	);

	dts_ram #(.WIDTH(VW + CW), .DEPTH(MAX_VERTICES)) u_stack (
		.clk(clk), .we(cmd.edge_take && descend), .waddr(VW'(sp_q - NW'(1))),
		.wdata({top_v_q, next_rd}),
		.re(cmd.pop), .raddr(VW'(sp_q - NW'(2))), .rdata(stack_rd)
	);

	dts_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
		.clk(clk), .we(cmd.pop), .waddr(fin_q[VW-1:0]), .wdata(top_v_q),
		.re(cmd.emit_read), .raddr(idx_q), .rdata(finish_rd)
	);

	// Control registers: count, fill level, marks, pointers, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= dts_pkg::COUNT_RESET;
			used_q      <= '0;
			has_list_q  <= '0;
			visited_q   <= '0;
			root_q      <= '0;
			sp_q        <= '0;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.edge_link) begin
				has_list_q[from_q] <= 1'b1;
				used_q             <= used_q + CW'(1);
			end
			if (cmd.clr) begin
				visited_q <= '0;
				root_q    <= '0;
				fin_q     <= '0;
			end
			if (cmd.root_next) begin
				root_q <= root_q + NW'(1);
			end
			if (cmd.root_start) begin
				visited_q[root_q[VW-1:0]] <= 1'b1;
				sp_q                      <= NW'(1);
			end
			if (cmd.edge_take && descend) begin
				visited_q[dest_rd] <= 1'b1;
				sp_q               <= sp_q + NW'(1);
			end
			if (cmd.pop) begin
				fin_q <= fin_q + NW'(1);
				sp_q  <= sp_q - NW'(1);
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit_load || cmd.reply_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.edge_accept) begin
			from_q   <= edge_from[VW-1:0];
			status_q <= acc_status;
		end
		if (cmd.root_start) begin
			top_v_q <= root_q[VW-1:0];
		end
		if (cmd.edge_take) begin
			if (descend) begin
				top_v_q <= dest_rd;
			end else begin
				top_cur_q <= next_rd;
			end
		end
		if (cmd.load_head) begin
			top_cur_q <= has_list_q[top_v_q] ? CW'(head_rd) : NIL;
		end
		if (cmd.pop_load) begin
			top_v_q   <= stack_rd[VW+CW-1:CW];
			top_cur_q <= stack_rd[CW-1:0];
		end
		if (cmd.emit_init) begin
			idx_q <= VW'(fin_q - NW'(1));
		end
		if (cmd.emit_load) begin
			idx_q        <= idx_q - VW'(1);
			out_vertex_q <= finish_rd;
			out_last_q   <= stat.idx_zero;
			out_status_q <= dts_pkg::ST_OK;
		end
		if (cmd.reply_load) begin
			out_vertex_q <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = dts_pkg::VERTEX_W'(out_vertex_q);
	assign last      = out_last_q;
	assign status    = out_status_q;

	// Stacks and edge store stay in bounds; no held output overwrite, no empty pop
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n) sp_q <= NMAX)
		else $error("search stack overflow");
	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n) fin_q <= NMAX)
		else $error("finish stack overflow");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n) used_q <= NIL)
		else $error("edge store overfilled");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load || cmd.reply_load) |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while held");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (sp_q != '0))
		else $error("pop from empty search stack");

endmodule

>>> src/dts_ctrl.sv
// Controller: sequences edge loads, the depth-first search and the order emission.
`timescale 1ns / 1ps

module dts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  dts_pkg::stat_t stat,
	output dts_pkg::cmd_t  cmd
);

	dts_pkg::state_t state_q, state_d;
	logic            in_xfer;

	assign in_stall = (state_q != dts_pkg::S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dts_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (stat.is_sort) begin
						state_d = dts_pkg::S_CLR;
					end else if (stat.edge_ok) begin
						state_d = dts_pkg::S_LINK;
					end else begin
						state_d = dts_pkg::S_REPLY;
					end
				end
			end
			dts_pkg::S_LINK:  state_d = dts_pkg::S_REPLY;
			dts_pkg::S_REPLY: begin
				if (stat.out_free) begin
					state_d = dts_pkg::S_IDLE;
				end
			end
			dts_pkg::S_CLR:   state_d = dts_pkg::S_ROOT;
			dts_pkg::S_ROOT: begin
				if (stat.root_done) begin
					state_d = dts_pkg::S_ERD;
				end else if (!stat.root_seen) begin
					state_d = dts_pkg::S_ROOTH;
				end
			end
			dts_pkg::S_ROOTH: state_d = dts_pkg::S_VISIT;
			dts_pkg::S_VISIT: begin
				if (!stat.top_nil) begin
					state_d = dts_pkg::S_EDGE;
				end else if (stat.sp_one) begin
					state_d = dts_pkg::S_ROOT;
				end else begin
					state_d = dts_pkg::S_POP;
				end
			end
			dts_pkg::S_EDGE:  state_d = stat.descend ? dts_pkg::S_HEAD : dts_pkg::S_VISIT;
			dts_pkg::S_HEAD:  state_d = dts_pkg::S_VISIT;
			dts_pkg::S_POP:   state_d = dts_pkg::S_VISIT;
			dts_pkg::S_ERD:   state_d = dts_pkg::S_EOUT;
			dts_pkg::S_EOUT: begin
				if (stat.out_free) begin
					state_d = stat.idx_zero ? dts_pkg::S_IDLE : dts_pkg::S_ERD;
				end
			end
			default: state_d = dts_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			dts_pkg::S_IDLE:  cmd.edge_accept = in_xfer && !stat.is_sort;
			dts_pkg::S_LINK:  cmd.edge_link = 1'b1;
			dts_pkg::S_REPLY: cmd.reply_load = stat.out_free;
			dts_pkg::S_CLR:   cmd.clr = 1'b1;
			dts_pkg::S_ROOT: begin
				if (stat.root_done) begin
					cmd.emit_init = 1'b1;
				end else if (stat.root_seen) begin
					cmd.root_next = 1'b1;
				end else begin
					cmd.root_start = 1'b1;
				end
			end
			dts_pkg::S_ROOTH: cmd.load_head = 1'b1;
			dts_pkg::S_VISIT: begin
				if (!stat.top_nil) begin
					cmd.edge_read = 1'b1;
				end else begin
					cmd.pop       = 1'b1;
					cmd.root_next = stat.sp_one;
				end
			end
			dts_pkg::S_EDGE:  cmd.edge_take = 1'b1;
			dts_pkg::S_HEAD:  cmd.load_head = 1'b1;
			dts_pkg::S_POP:   cmd.pop_load = 1'b1;
			dts_pkg::S_ERD:   cmd.emit_read = 1'b1;
			dts_pkg::S_EOUT:  cmd.emit_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

	// A sort never leaves the search with the input side open
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dts_pkg::S_VISIT) |-> in_stall)
		else $error("input open during search");

endmodule

>>> src/dfs_topological_sort_core.sv
// Top level of the DFS topological sort core.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  input   | in_valid / in_stall   | req_type, edge_from, edge_to
//  output  | out_valid / out_stall | vertex, last, status
//  config  | cfg_we                | cfg_wdata (vertex_count)
//
// An edge add passes the link state (if accepted) and the reply state before
// the next transfer; the reply waits in the output register. A sort checks
// each root, visits each vertex, walks each stored edge, then emits each
// finished vertex, paced by the one-read-per-cycle list and stack memories.
// Reset is asynchronous; all lists read empty at once, there is no clearing pass.
// A stalled output holds the sequencer; no input is taken until a sort finishes.
`timescale 1ns / 1ps

module dfs_topological_sort_core #(
	parameter int MAX_VERTICES = dts_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = dts_pkg::MAX_EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dts_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [dts_pkg::VERTEX_W-1:0]  edge_from,
	input  logic [dts_pkg::VERTEX_W-1:0]  edge_to,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dts_pkg::VERTEX_W-1:0]  vertex,
	output logic                          last,
	output logic [dts_pkg::STATUS_W-1:0]  status
);

	dts_pkg::cmd_t  cmd;
	dts_pkg::stat_t stat;

	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dts_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_type  (req_type),
		.edge_from (edge_from),
		.edge_to   (edge_to),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.vertex    (vertex),
		.last      (last),
		.status    (status)
	);

endmodule
